FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of the grid path block.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that is switched off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is switched off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/gmcp_pkg.sv
// Shared types and constants of the grid minimum cost path block.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package gmcp_pkg;

   localparam int MAX_COLS_DEF = 64;
   localparam int MAX_ROWS_DEF = 64;

   localparam int COST_W    = 16;
   localparam int SUM_W     = 32;
   localparam int CNT_W     = 7;
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = CSR_IDX_W'(1);

   localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'(1);

   typedef logic signed [SUM_W-1:0] sum_type;

   // Per-cell control: shift the line, and whether this cell takes the new sum.
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

FILE: sv/gmcp_cell.sv
// One cell of the row buffer shift line: holds one partial sum of the row below.
// Depends on gmcp_pkg.
`timescale 1ns / 1ps

module gmcp_cell (
   input  logic                    clock,
   input  gmcp_pkg::cell_ctrl_type ctrl,
   input  gmcp_pkg::sum_type       sum_new,
   input  gmcp_pkg::sum_type       sum_prev,
   output gmcp_pkg::sum_type       held_ff
);

   gmcp_pkg::sum_type held_in;

   always_comb begin
      held_in = held_ff;
      if (ctrl.shift) begin
         held_in = ctrl.load ? sum_new : sum_prev;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

FILE: sv/grid_min_cost_path.sv
// Grid minimum cost path: one cell cost accepted per cycle, back to back, while ready.
// The result is registered and appears in the cycle after the top-left cell is accepted.
// Throughput: one cell per cycle while ready, set by the sum loop to the left neighbor.
// Reset (synchronous): sizes return to 1, position counters clear, no result pending.
// The row buffer shift line is not cleared; the bottom row fills every entry used.
`timescale 1ns / 1ps

module grid_min_cost_path #(
   parameter int MAX_COLS = gmcp_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = gmcp_pkg::MAX_ROWS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [gmcp_pkg::COST_W-1:0]   req_cell_cost,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [gmcp_pkg::SUM_W-1:0]    rsp_min_sum,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gmcp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gmcp_pkg::CNT_W-1:0]           csr_data
);

   localparam int CNT_W    = gmcp_pkg::CNT_W;
   localparam int CNT_MAX  = (1 << CNT_W) - 1;
   localparam int RowLimit = (MAX_ROWS < CNT_MAX) ? MAX_ROWS : CNT_MAX;
   localparam int ColLimit = (MAX_COLS < CNT_MAX) ? MAX_COLS : CNT_MAX;
   localparam int IDX_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic [CNT_W-1:0] row_count_ff, row_count_in;
   logic [CNT_W-1:0] col_count_ff, col_count_in;
   logic [CNT_W-1:0] row_pos_ff, row_pos_in;
   logic [CNT_W-1:0] col_pos_ff, col_pos_in;
   gmcp_pkg::sum_type right_ff, right_in;
   gmcp_pkg::sum_type diag_ff, diag_in;
   logic              rsp_valid_ff, rsp_valid_in;
   gmcp_pkg::sum_type rsp_sum_ff, rsp_sum_in;

   logic [CNT_W-1:0]  rows_eff, cols_eff;
   logic [IDX_W-1:0]  ins_pos;
   logic              accept, csr_write, last_col, last_cell;
   gmcp_pkg::sum_type cost, below, best, sum;
   gmcp_pkg::sum_type line [MAX_COLS];

   // Zero acts as one; values above the maximum saturate to it.
   always_comb begin
      rows_eff = row_count_ff;
      if (row_count_ff == '0) begin
         rows_eff = CNT_W'(1);
      end else if (32'(row_count_ff) > RowLimit) begin
         rows_eff = CNT_W'(RowLimit);
      end
      cols_eff = col_count_ff;
      if (col_count_ff == '0) begin
         cols_eff = CNT_W'(1);
      end else if (32'(col_count_ff) > ColLimit) begin
         cols_eff = CNT_W'(ColLimit);
      end
   end

   // New sums enter the line where they reach the far end after one row.
   assign ins_pos = IDX_W'(MAX_COLS - 32'(cols_eff));

   assign last_col  = (col_pos_ff == cols_eff - CNT_W'(1));
   assign last_cell = last_col && (row_pos_ff == rows_eff - CNT_W'(1));

   // Only the top-left cell needs room in the output register.
   assign req_ready = !(rsp_valid_ff && !rsp_ready && last_cell);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign cost  = gmcp_pkg::SUM_W'(req_cell_cost);
   assign below = line[MAX_COLS-1];

   always_comb begin
      best = below;
      if (diag_ff < best) begin
         best = diag_ff;
      end
      if (right_ff < best) begin
         best = right_ff;
      end
      if (row_pos_ff == '0 && col_pos_ff == '0) begin
         sum = cost;
      end else if (row_pos_ff == '0) begin
         sum = right_ff + cost;
      end else if (col_pos_ff == '0) begin
         sum = below + cost;
      end else begin
         sum = best + cost;
      end
   end

   for (genvar k = 0; k < MAX_COLS; k++) begin : g_line
      gmcp_pkg::cell_ctrl_type ctrl;
      assign ctrl.shift = accept;
      assign ctrl.load  = (ins_pos == IDX_W'(k));
      if (k == 0) begin : g_head
         gmcp_cell u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .sum_new  (sum),
            .sum_prev (sum),
            .held_ff  (line[k])
         );
      end else begin : g_body
         gmcp_cell u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .sum_new  (sum),
            .sum_prev (line[k-1]),
            .held_ff  (line[k])
         );
      end
   end

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      row_pos_in   = row_pos_ff;
      col_pos_in   = col_pos_ff;
      right_in     = right_ff;
      diag_in      = diag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sum_in   = rsp_sum_ff;
      if (accept) begin
         diag_in  = below;
         right_in = sum;
         if (last_col) begin
            col_pos_in = '0;
            row_pos_in = last_cell ? '0 : row_pos_ff + CNT_W'(1);
         end else begin
            col_pos_in = col_pos_ff + CNT_W'(1);
         end
         if (last_cell) begin
            rsp_valid_in = 1'b1;
            rsp_sum_in   = sum;
         end
      end
      if (csr_write) begin
         unique case (csr_index)
            gmcp_pkg::CSR_ROW_COUNT: begin
               row_count_in = csr_data;
               row_pos_in   = '0;
               col_pos_in   = '0;
            end
            gmcp_pkg::CSR_COL_COUNT: begin
               col_count_in = csr_data;
               row_pos_in   = '0;
               col_pos_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= gmcp_pkg::SIZE_RESET;
         col_count_ff <= gmcp_pkg::SIZE_RESET;
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         right_ff     <= '0;
         diag_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         right_ff     <= right_in;
         diag_ff      <= diag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_min_sum = rsp_sum_ff;

endmodule

FILE: sv/gmcp_checker.sv
// Port-level checks of the grid minimum cost path block, bound to its top level.
// Depends on gmcp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gmcp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [gmcp_pkg::SUM_W-1:0]   rsp_min_sum
);

   // A result only ever follows an accepted request.
   `ASSERT_IMPLY(a_rsp_after_req, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready))
   // Reset leaves no result pending.
   `ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)
   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_min_sum))

endmodule

bind grid_min_cost_path gmcp_checker u_gmcp_checker (.*);
